/* src/assert_macros.svh */
// Assertion macros shared by the rotation unit. Each one samples on the rising
// edge of clk and is switched off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent in the current cycle implies consequent in the same cycle.
`define QVR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent in the current cycle implies consequent in the next cycle.
`define QVR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/qvr_pkg.sv */
package qvr_pkg;

    // Field and intermediate widths.
    localparam int QW     = 16;   // quaternion and vector components
    localparam int P1_W   = 32;   // Q1.14 by integer product
    localparam int T_W    = 33;   // first Hamilton product, sum of three products
    localparam int P2_W   = 49;   // first product term by Q1.14
    localparam int R_W    = 52;   // second Hamilton product, sum of four terms
    localparam int FRAC   = 28;   // fraction bits of the second product
    localparam int NPROD  = 12;   // multiplications in each product stage

    localparam logic [QW-1:0] SAT_POS = 16'h7FFF;
    localparam logic [QW-1:0] SAT_NEG = 16'h8000;

    typedef logic signed [QW-1:0]   qvr_s16_t;
    typedef logic signed [P1_W-1:0] qvr_p1_t;
    typedef logic signed [T_W-1:0]  qvr_t33_t;
    typedef logic signed [P2_W-1:0] qvr_p2_t;
    typedef logic signed [R_W-1:0]  qvr_r52_t;

    // Input transaction.
    typedef struct packed {
        qvr_s16_t quat_w;
        qvr_s16_t quat_x;
        qvr_s16_t quat_y;
        qvr_s16_t quat_z;
        qvr_s16_t vec_x;
        qvr_s16_t vec_y;
        qvr_s16_t vec_z;
    } qvr_in_t;

    // Output transaction.
    typedef struct packed {
        qvr_s16_t rot_x;
        qvr_s16_t rot_y;
        qvr_s16_t rot_z;
        logic     clipped;
    } qvr_out_t;

    typedef struct packed {
        qvr_s16_t w;
        qvr_s16_t x;
        qvr_s16_t y;
        qvr_s16_t z;
    } qvr_quat_t;

    // Result of q * (0, v), carried with the quaternion it still needs.
    typedef struct packed {
        qvr_quat_t q;
        qvr_t33_t  tw;
        qvr_t33_t  tx;
        qvr_t33_t  ty;
        qvr_t33_t  tz;
    } qvr_mid_t;

    // Vector part of the second product, 28 fraction bits.
    typedef struct packed {
        qvr_r52_t rx;
        qvr_r52_t ry;
        qvr_r52_t rz;
    } qvr_rvec_t;

endpackage

/* src/quaternion_vector_rotate_unit.sv */
// Quaternion vector rotation unit.
//
// The input channel (vec_valid, vec_stall, vec_data) carries a quaternion in
// Q1.14 and a vector of signed integers. The output channel (rot_valid,
// rot_stall, rot_data) returns q * (0, v) * conj(q), rounded to nearest with
// ties away from zero and saturated to 16 bits; clipped is set when any
// component saturated. A quaternion that is not unit length also scales the
// result by its squared norm.
//
// A transaction is taken when valid is high and stall is low. The five register
// stages are component products, first sums, second products, second sums, then
// rounding and saturation; the unit takes one transaction per cycle while no
// stall holds it back.
//
// When the receiver raises rot_stall, the output holds its transaction and
// the stages behind it keep filling until each is occupied; only then is
// vec_stall raised. Nothing is dropped or repeated. Reset clears every valid
// bit, so the pipeline comes up empty and ready for a transaction.
module quaternion_vector_rotate_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              vec_valid,
    output logic              vec_stall,
    input  qvr_pkg::qvr_in_t  vec_data,
    output logic              rot_valid,
    input  logic              rot_stall,
    output qvr_pkg::qvr_out_t rot_data
);
    import qvr_pkg::*;

    logic      mid_valid;
    logic      mid_stall;
    qvr_mid_t  mid_data;
    logic      r_valid;
    logic      r_stall;
    qvr_rvec_t r_data;

    // First Hamilton product t = q * (0, v).
    qvr_first_prod u_first (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vec_valid),
        .in_stall  (vec_stall),
        .in_data   (vec_data),
        .out_valid (mid_valid),
        .out_stall (mid_stall),
        .out_data  (mid_data)
    );

    // Second Hamilton product t * conj(q), vector part.
    qvr_second_prod u_second (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mid_valid),
        .in_stall  (mid_stall),
        .in_data   (mid_data),
        .out_valid (r_valid),
        .out_stall (r_stall),
        .out_data  (r_data)
    );

    // Rounding, saturation and the output register.
    qvr_round_sat u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (r_valid),
        .in_stall  (r_stall),
        .in_data   (r_data),
        .out_valid (rot_valid),
        .out_stall (rot_stall),
        .out_data  (rot_data)
    );

    // A clipped transaction carries at least one component at a saturation limit.
    `QVR_ASSERT_SAME(a_clip_at_limit, rot_valid && rot_data.clipped, rot_data.rot_x == SAT_POS || rot_data.rot_x == SAT_NEG || rot_data.rot_y == SAT_POS || rot_data.rot_y == SAT_NEG || rot_data.rot_z == SAT_POS || rot_data.rot_z == SAT_NEG, "clipped set without a saturated component")

endmodule

/* src/qvr_first_prod.sv */
`include "assert_macros.svh"

module qvr_first_prod (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  qvr_pkg::qvr_in_t in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output qvr_pkg::qvr_mid_t out_data
);
    import qvr_pkg::*;

    logic      s1_valid_reg;
    logic      s2_valid_reg;
    logic      s1_en;
    logic      s2_en;
    qvr_quat_t s1_quat_reg;
    qvr_p1_t   prod_reg [NPROD];
    qvr_p1_t   prod_next [NPROD];
    qvr_mid_t  s2_data_reg;
    qvr_mid_t  s2_data_next;

    // A stage loads when it is empty or its contents move on.
    assign s2_en    = !s2_valid_reg || !out_stall;
    assign s1_en    = !s1_valid_reg || s2_en;
    assign in_stall = !s1_en;

    // Stage one: the twelve component products of q and v.
    always_comb
    begin
        prod_next[0]  = P1_W'(in_data.quat_x) * P1_W'(in_data.vec_x);
        prod_next[1]  = P1_W'(in_data.quat_y) * P1_W'(in_data.vec_y);
        prod_next[2]  = P1_W'(in_data.quat_z) * P1_W'(in_data.vec_z);
        prod_next[3]  = P1_W'(in_data.quat_w) * P1_W'(in_data.vec_x);
        prod_next[4]  = P1_W'(in_data.quat_y) * P1_W'(in_data.vec_z);
        prod_next[5]  = P1_W'(in_data.quat_z) * P1_W'(in_data.vec_y);
        prod_next[6]  = P1_W'(in_data.quat_w) * P1_W'(in_data.vec_y);
        prod_next[7]  = P1_W'(in_data.quat_x) * P1_W'(in_data.vec_z);
        prod_next[8]  = P1_W'(in_data.quat_z) * P1_W'(in_data.vec_x);
        prod_next[9]  = P1_W'(in_data.quat_w) * P1_W'(in_data.vec_z);
        prod_next[10] = P1_W'(in_data.quat_x) * P1_W'(in_data.vec_y);
        prod_next[11] = P1_W'(in_data.quat_y) * P1_W'(in_data.vec_x);
    end

    // Stage two: sum the products into the four components of t.
    always_comb
    begin
        s2_data_next.q  = s1_quat_reg;
        s2_data_next.tw = -T_W'(prod_reg[0]) - T_W'(prod_reg[1]) - T_W'(prod_reg[2]);
        s2_data_next.tx = T_W'(prod_reg[3]) + T_W'(prod_reg[4]) - T_W'(prod_reg[5]);
        s2_data_next.ty = T_W'(prod_reg[6]) - T_W'(prod_reg[7]) + T_W'(prod_reg[8]);
        s2_data_next.tz = T_W'(prod_reg[9]) + T_W'(prod_reg[10]) - T_W'(prod_reg[11]);
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_en)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_en)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s1_en)
        begin
            s1_quat_reg.w <= in_data.quat_w;
            s1_quat_reg.x <= in_data.quat_x;
            s1_quat_reg.y <= in_data.quat_y;
            s1_quat_reg.z <= in_data.quat_z;
            for (int i = 0; i < NPROD; i++)
            begin
                prod_reg[i] <= prod_next[i];
            end
        end
        if (s2_en)
        begin
            s2_data_reg <= s2_data_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_data  = s2_data_reg;

    // Upstream is held off only when both stages are occupied.
    `QVR_ASSERT_SAME(a_first_stall_full, in_stall, s1_valid_reg && s2_valid_reg, "first product stalled with a free stage")

endmodule

/* src/qvr_second_prod.sv */
`include "assert_macros.svh"

module qvr_second_prod (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  qvr_pkg::qvr_mid_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output qvr_pkg::qvr_rvec_t out_data
);
    import qvr_pkg::*;

    logic      s3_valid_reg;
    logic      s4_valid_reg;
    logic      s3_en;
    logic      s4_en;
    qvr_p2_t   prod_reg [NPROD];
    qvr_p2_t   prod_next [NPROD];
    qvr_rvec_t s4_data_reg;
    qvr_rvec_t s4_data_next;

    assign s4_en    = !s4_valid_reg || !out_stall;
    assign s3_en    = !s3_valid_reg || s4_en;
    assign in_stall = !s3_en;

    // Stage three: each component of t times the quaternion components it meets.
    always_comb
    begin
        prod_next[0]  = P2_W'(in_data.tw) * P2_W'(in_data.q.x);
        prod_next[1]  = P2_W'(in_data.tw) * P2_W'(in_data.q.y);
        prod_next[2]  = P2_W'(in_data.tw) * P2_W'(in_data.q.z);
        prod_next[3]  = P2_W'(in_data.tx) * P2_W'(in_data.q.w);
        prod_next[4]  = P2_W'(in_data.tx) * P2_W'(in_data.q.z);
        prod_next[5]  = P2_W'(in_data.tx) * P2_W'(in_data.q.y);
        prod_next[6]  = P2_W'(in_data.ty) * P2_W'(in_data.q.z);
        prod_next[7]  = P2_W'(in_data.ty) * P2_W'(in_data.q.w);
        prod_next[8]  = P2_W'(in_data.ty) * P2_W'(in_data.q.x);
        prod_next[9]  = P2_W'(in_data.tz) * P2_W'(in_data.q.y);
        prod_next[10] = P2_W'(in_data.tz) * P2_W'(in_data.q.x);
        prod_next[11] = P2_W'(in_data.tz) * P2_W'(in_data.q.w);
    end

    // Stage four: signed sums give the vector part of t * conj(q).
    always_comb
    begin
        s4_data_next.rx = -R_W'(prod_reg[0]) + R_W'(prod_reg[3])
                          - R_W'(prod_reg[6]) + R_W'(prod_reg[9]);
        s4_data_next.ry = -R_W'(prod_reg[1]) + R_W'(prod_reg[4])
                          + R_W'(prod_reg[7]) - R_W'(prod_reg[10]);
        s4_data_next.rz = -R_W'(prod_reg[2]) - R_W'(prod_reg[5])
                          + R_W'(prod_reg[8]) + R_W'(prod_reg[11]);
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s3_en)
            begin
                s3_valid_reg <= in_valid;
            end
            if (s4_en)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s3_en)
        begin
            for (int i = 0; i < NPROD; i++)
            begin
                prod_reg[i] <= prod_next[i];
            end
        end
        if (s4_en)
        begin
            s4_data_reg <= s4_data_next;
        end
    end

    assign out_valid = s4_valid_reg;
    assign out_data  = s4_data_reg;

    `QVR_ASSERT_SAME(a_second_stall_full, in_stall, s3_valid_reg && s4_valid_reg, "second product stalled with a free stage")

endmodule

/* src/qvr_round_sat.sv */
`include "assert_macros.svh"

module qvr_round_sat (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  qvr_pkg::qvr_rvec_t in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output qvr_pkg::qvr_out_t  out_data
);
    import qvr_pkg::*;

    localparam int SW = R_W - FRAC;

    logic     out_valid_reg;
    logic     en;
    qvr_out_t out_data_reg;
    qvr_out_t out_data_next;
    logic [QW:0] res_x;
    logic [QW:0] res_y;
    logic [QW:0] res_z;

    // Rounds to nearest with ties away from zero, then saturates. Subtracting
    // one from the bias for negative values turns the floor into a round away
    // from zero on an exact half. The top bit of the result is the clip flag.
    function automatic logic [QW:0] round_sat(input qvr_r52_t r);
        logic [R_W-1:0] biased;
        logic [SW-1:0]  s;
        logic           clip;
        logic [QW-1:0]  val;
        biased = r + R_W'(1) * (R_W'(1) << (FRAC - 1)) - R_W'(r[R_W-1]);
        s      = biased[R_W-1:FRAC];
        clip   = !((&s[SW-1:QW-1]) || !(|s[SW-1:QW-1]));
        if (clip)
        begin
            val = s[SW-1] ? SAT_NEG : SAT_POS;
        end
        else
        begin
            val = s[QW-1:0];
        end
        return {clip, val};
    endfunction

    assign en       = !out_valid_reg || !out_stall;
    assign in_stall = !en;

    // Final stage: round and saturate all three components.
    always_comb
    begin
        res_x = round_sat(in_data.rx);
        res_y = round_sat(in_data.ry);
        res_z = round_sat(in_data.rz);
        out_data_next.rot_x   = res_x[QW-1:0];
        out_data_next.rot_y   = res_y[QW-1:0];
        out_data_next.rot_z   = res_z[QW-1:0];
        out_data_next.clipped = res_x[QW] | res_y[QW] | res_z[QW];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // A transaction taken in shows up at the output register on the next cycle.
    `QVR_ASSERT_NEXT(a_round_lands, in_valid && !in_stall, out_valid, "rounding stage lost a transaction")

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    import qvr_pkg::*;

    localparam int CLK_PERIOD   = 4;
    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_ITEMS = 1630;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 20;

    // The second product carries 28 fraction bits; half an LSB of the result.
    localparam int          ROUND_SHIFT = 28;
    localparam longint unsigned HALF_LSB = 64'd1 << (ROUND_SHIFT - 1);

    // Quaternion components for 1.0, for 0.5 and for roughly cos(45 degrees).
    localparam int Q_ONE  = 16384;
    localparam int Q_HALF = 8192;
    localparam int Q_R2   = 11585;

    typedef struct {
        qvr_in_t  stim;
        bit       typed;
        qvr_out_t want;
    } dir_row_t;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     vec_valid = 1'b0;
    logic     vec_stall;
    qvr_in_t  vec_data  = '0;
    logic     rot_valid;
    logic     rot_stall = 1'b0;
    qvr_out_t rot_data;

    dir_row_t dir_rows [$];
    qvr_out_t rot_expected [$];
    qvr_out_t rot_want;
    int       mismatch_count = 0;
    int       cycle_count    = 0;
    bit       calm_phase     = 1'b0;

    quaternion_vector_rotate_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .vec_valid (vec_valid),
        .vec_stall (vec_stall),
        .vec_data  (vec_data),
        .rot_valid (rot_valid),
        .rot_stall (rot_stall),
        .rot_data  (rot_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Rounds a value with 28 fraction bits to nearest, ties away from zero, and
    // saturates it to 16 bits. Bit 16 of the return value flags saturation.
    function automatic logic [16:0] round_saturate(input longint acc);
        longint unsigned mag;
        longint unsigned whole;
        longint unsigned neg_whole;
        logic            clip;
        clip = 1'b0;
        mag = (acc < 0) ? -acc : acc;
        whole = (mag + HALF_LSB) >> ROUND_SHIFT;
        if (acc < 0)
        begin
            if (whole > 64'd32768)
            begin
                clip  = 1'b1;
                whole = 64'd32768;
            end
            neg_whole = -whole;
            return {clip, neg_whole[15:0]};
        end
        if (whole > 64'd32767)
        begin
            clip  = 1'b1;
            whole = 64'd32767;
        end
        return {clip, whole[15:0]};
    endfunction

    // Rotates the vector by the quaternion as q * (0, v) * conj(q), exact until
    // the final rounding.
    function automatic qvr_out_t predict_rotation(input qvr_in_t item);
        longint      w, x, y, z, vx, vy, vz;
        longint      tw, tx, ty, tz;
        longint      rx, ry, rz;
        logic [16:0] cx, cy, cz;
        qvr_out_t    res;
        w  = item.quat_w;
        x  = item.quat_x;
        y  = item.quat_y;
        z  = item.quat_z;
        vx = item.vec_x;
        vy = item.vec_y;
        vz = item.vec_z;
        tw = -x * vx - y * vy - z * vz;
        tx =  w * vx + y * vz - z * vy;
        ty =  w * vy - x * vz + z * vx;
        tz =  w * vz + x * vy - y * vx;
        rx = -tw * x + tx * w - ty * z + tz * y;
        ry = -tw * y + tx * z + ty * w - tz * x;
        rz = -tw * z - tx * y + ty * x + tz * w;
        cx = round_saturate(rx);
        cy = round_saturate(ry);
        cz = round_saturate(rz);
        res.rot_x   = cx[15:0];
        res.rot_y   = cy[15:0];
        res.rot_z   = cz[15:0];
        res.clipped = cx[16] | cy[16] | cz[16];
        return res;
    endfunction

    function automatic qvr_in_t make_stim(input int w, input int x, input int y, input int z,
                                          input int vx, input int vy, input int vz);
        qvr_in_t item;
        item.quat_w = qvr_s16_t'(w);
        item.quat_x = qvr_s16_t'(x);
        item.quat_y = qvr_s16_t'(y);
        item.quat_z = qvr_s16_t'(z);
        item.vec_x  = qvr_s16_t'(vx);
        item.vec_y  = qvr_s16_t'(vy);
        item.vec_z  = qvr_s16_t'(vz);
        return item;
    endfunction

    task automatic add_row(input int w, input int x, input int y, input int z,
                           input int vx, input int vy, input int vz, input bit typed,
                           input int ex, input int ey, input int ez, input bit ec);
        dir_row_t row;
        row.stim          = make_stim(w, x, y, z, vx, vy, vz);
        row.typed         = typed;
        row.want.rot_x    = qvr_s16_t'(ex);
        row.want.rot_y    = qvr_s16_t'(ey);
        row.want.rot_z    = qvr_s16_t'(ez);
        row.want.clipped  = ec;
        dir_rows.push_back(row);
    endtask

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int pick_idle();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm_phase || roll < 55)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // A field value biased towards the extremes, zero, minus one and small values.
    function automatic int rand_field();
        case ($urandom_range(0, 15))
            0:       return -32768;
            1:       return 32767;
            2:       return 0;
            3:       return -1;
            4, 5, 6: return int'($urandom_range(0, 128)) - 64;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    // A quaternion component of at most about unit size, so that the rotation
    // mostly stays in range.
    function automatic int rand_unitish();
        return int'($urandom_range(0, 2 * Q_R2)) - Q_R2;
    endfunction

    // Offers one input transaction after a random gap and records its expected
    // result once it has been taken.
    task automatic send_item(input qvr_in_t item, input qvr_out_t want);
        int gap;
        gap = pick_idle();
        if (gap > 0)
        begin
            vec_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        vec_valid <= 1'b1;
        vec_data  <= item;
        @(posedge clk);
        while (vec_stall)
            @(posedge clk);
        rot_expected.push_back(want);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Stimulus: directed table first, then random transactions.
    initial
    begin : stimulus
        qvr_in_t item;
        int      n;
        int      mode;

        // Zero input, identity rotations and half-turns about each axis.
        add_row(0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0);
        add_row(Q_ONE, 0, 0, 0, 32767, -32768, 0, 1, 32767, -32768, 0, 0);
        add_row(Q_ONE, 0, 0, 0, -1, 1, 12345, 1, -1, 1, 12345, 0);
        add_row(0, Q_ONE, 0, 0, 100, 200, -32768, 1, 100, -200, 32767, 1);
        add_row(0, 0, Q_ONE, 0, -32768, 5, -7, 1, 32767, 5, 7, 1);
        add_row(0, 0, 0, Q_ONE, 3, -4, 32767, 1, -3, 4, 32767, 0);
        add_row(0, Q_ONE, 0, 0, -32768, -32768, -32768, 1, -32768, 32767, 32767, 1);
        // A raw -32768 scalar is -2.0, which scales the vector by four.
        add_row(-32768, 0, 0, 0, 1, -1, 0, 1, 4, -4, 0, 0);
        add_row(-32768, 0, 0, 0, -32768, -32768, -32768, 1, -32768, -32768, -32768, 1);
        add_row(-32768, 0, 0, 0, 32767, 8191, -8192, 1, 32767, 32764, -32768, 1);
        // A scalar of one half scales by a quarter: exact halves round away from zero.
        add_row(Q_HALF, 0, 0, 0, 2, -2, 1, 1, 1, -1, 0, 0);
        add_row(Q_HALF, 0, 0, 0, 6, -6, -1, 1, 2, -2, 0, 0);
        add_row(Q_HALF, 0, 0, 0, 3, -3, 32767, 1, 1, -1, 8192, 0);
        // The smallest scalar makes every result round to zero.
        add_row(1, 0, 0, 0, 32767, 32767, 32767, 1, 0, 0, 0, 0);
        // Rows left to the predictor: field extremes and general rotations.
        add_row(32767, 32767, 32767, 32767, 32767, 32767, 32767, 0, 0, 0, 0, 0);
        add_row(-32768, -32768, -32768, -32768, -32768, -32768, -32768, 0, 0, 0, 0, 0);
        add_row(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 0, 0, 0, 0, 0);
        add_row(32767, -32768, 32767, -32768, -32768, 32767, -32768, 0, 0, 0, 0, 0);
        add_row(Q_R2, 0, 0, Q_R2, 1000, 0, 0, 0, 0, 0, 0, 0);
        add_row(Q_R2, Q_R2, 0, 0, 0, 1000, -1000, 0, 0, 0, 0, 0);
        add_row(Q_HALF, Q_HALF, Q_HALF, Q_HALF, 300, -700, 900, 0, 0, 0, 0, 0);

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            send_item(dir_rows[i].stim,
                      dir_rows[i].typed ? dir_rows[i].want : predict_rotation(dir_rows[i].stim));
        end

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            // Now and then a stretch with no idling on either side.
            if (n % 100 == 0)
                calm_phase = ($urandom_range(0, 3) == 0);
            mode = $urandom_range(0, 4);
            if (mode < 2)
                item = make_stim(rand_unitish(), rand_unitish(), rand_unitish(),
                                 rand_unitish(), rand_field(), rand_field(), rand_field());
            else if (mode < 4)
                item = make_stim(rand_field(), rand_field(), rand_field(), rand_field(),
                                 rand_field(), rand_field(), rand_field());
            else
                item = make_stim($urandom, $urandom, $urandom, $urandom,
                                 $urandom, $urandom, $urandom);
            send_item(item, predict_rotation(item));
        end
        vec_valid <= 1'b0;
        calm_phase = 1'b0;

        // Drain the pipeline, then allow a few cycles for any stray result.
        while (rot_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Receiver back-pressure: random stall bursts between random ready runs.
    initial
    begin : receiver
        int hold;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            hold = pick_idle();
            if (hold > 0)
            begin
                rot_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            rot_stall <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    // Compare each accepted result transaction with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && rot_valid && !rot_stall)
        begin
            if (rot_expected.size() == 0)
            begin
                $display("%0t: result with none expected, got %p", $time, rot_data);
                mismatch_count++;
            end
            else
            begin
                rot_want = rot_expected.pop_front();
                check_field("rot_x", rot_want.rot_x, rot_data.rot_x);
                check_field("rot_y", rot_want.rot_y, rot_data.rot_y);
                check_field("rot_z", rot_want.rot_z, rot_data.rot_z);
                check_field("clipped", rot_want.clipped, rot_data.clipped);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, rot_expected.size());
            $display("TB_ERROR");
            $finish;
        end
    end

endmodule

/* filelist.f */
+incdir+src
src/qvr_pkg.sv
src/qvr_first_prod.sv
src/qvr_second_prod.sv
src/qvr_round_sat.sv
src/quaternion_vector_rotate_unit.sv
dv/tb_top.sv
